@@ rtl/has_pkg.sv @@
// Package for the hashed aggregator switch: types, codes and item layouts.
// Used by every module of the block; depends on nothing.
`default_nettype none
package has_pkg;

    localparam logic [1:0] OP_NORMAL = 2'd0;
    localparam logic [1:0] OP_RESEND = 2'd1;
    localparam logic [1:0] OP_SCAN   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] CFG_POOL    = 2'd0;
    localparam logic [1:0] CFG_ECN     = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    localparam logic [7:0] SWITCH_WORKER = 8'hFF;
    localparam logic [31:0] HASH_MUL     = 32'd31;

    typedef struct packed {
        logic        ecn_in;
        logic [5:0]  worker_count;
        logic [31:0] worker_mask;
        logic [5:0]  fan_in;
        logic [31:0] value;
        logic [4:0]  src_worker;
        logic [15:0] seq_num;
        logic [31:0] job_id;
        logic [1:0]  opcode;
    } t_in_item;

    typedef struct packed {
        logic        resent_out;
        logic        ecn_out;
        logic [5:0]  out_count;
        logic [31:0] out_mask;
        logic        sw_result;
        logic        collided;
        logic [5:0]  out_fan_in;
        logic [31:0] out_value;
        logic [7:0]  out_worker;
        logic [15:0] out_seq;
        logic [31:0] out_job_id;
    } t_out_item;

    typedef struct packed {
        logic [47:0] key;
        logic [31:0] sum;
        logic [31:0] mask;
        logic [5:0]  count;
        logic [31:0] stamp;
        logic        ecn;
    } t_slot;

endpackage
`default_nettype wire

@@ rtl/has_mod.sv @@
// Hash modulo unit: reduces a 32-bit hash modulo the pool size, one bit a cycle.
// Depends on has_pkg.
`default_nettype none
module has_mod
    import has_pkg::*;
#(
    parameter int W = 17
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [31:0]   i_num,
    input  wire logic [W-1:0]  i_div,
    output logic               o_done,
    output logic [W-1:0]       o_rem
);
    logic [31:0] r_num;
    logic [W:0]  r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [W:0]  v_sh;
    logic [W:0]  v_sub;

    always_comb begin
        v_sh  = {r_rem[W-1:0], r_num[31]};
        v_sub = v_sh - {1'b0, i_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_num  <= i_num;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[30:0], 1'b0};
                r_rem <= v_sub[W] ? v_sh : v_sub;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_rem = r_rem[W-1:0];
endmodule
`default_nettype wire

@@ rtl/has_rescue.sv @@
// Rescued pair FIFO: a memory of keys searched one entry a cycle.
// Depends on has_pkg.
`default_nettype none
module has_rescue
    import has_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_search,
    input  wire logic         i_push,
    input  wire logic [47:0]  i_key,
    output logic              o_done,
    output logic              o_hit
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic [47:0]   r_mem [DEPTH];
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] r_pos;
    logic          r_busy;
    logic          r_rvld;
    logic [47:0]   r_rdata;
    logic [AW-1:0] v_rd;
    logic [AW-1:0] v_wr;

    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {{(CW+1-AW){1'b0}}, a} + {1'b0, b};
        if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
        return s[AW-1:0];
    endfunction

    assign v_rd = wrap(r_head, r_pos);
    assign v_wr = wrap(r_head, (r_fill == FULL) ? '0 : r_fill);

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[v_rd];
        if (i_push) r_mem[v_wr] <= i_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
            r_pos  <= '0;
            r_busy <= 1'b0;
            r_rvld <= 1'b0;
            o_done <= 1'b0;
            o_hit  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            r_rvld <= 1'b0;
            if (i_push) begin
                if (r_fill == FULL) r_head <= wrap(r_head, CW'(1));
                else                r_fill <= r_fill + CW'(1);
            end
            if (i_search) begin
                r_pos  <= '0;
                o_hit  <= 1'b0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_rvld && r_rdata == i_key) o_hit <= 1'b1;
                if (r_pos >= r_fill) begin
                    if (!r_rvld) begin
                        r_busy <= 1'b0;
                        o_done <= 1'b1;
                    end
                end else begin
                    r_rvld <= 1'b1;
                    r_pos  <= r_pos + CW'(1);
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/has_pool.sv @@
// Slot pool memory with a registered read port and one write port.
// Depends on has_pkg.
`default_nettype none
module has_pool
    import has_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic                      i_clk,
    input  wire logic [$clog2(DEPTH+1)-1:0] i_raddr,
    output t_slot                          o_rdata,
    input  wire logic                      i_we,
    input  wire logic [$clog2(DEPTH+1)-1:0] i_waddr,
    input  t_slot                          i_wdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    t_slot r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr[AW-1:0]];
        if (i_we) r_mem[i_waddr[AW-1:0]] <= i_wdata;
    end
endmodule
`default_nettype wire

@@ rtl/hashed_aggregator_switch_top.sv @@
// Top level of the hashed aggregator switch: control sequencer and item registers.
// Depends on has_pkg, has_mod, has_rescue and has_pool.
//
//  channel   | direction | handshake              | payload
//  s_axis    | in        | s_axis_tvalid/tready   | opcode..ecn_in packed in tdata
//  m_axis    | out       | m_axis_tvalid/tready   | out_job_id..resent_out in tdata
//  cfg       | in        | i_cfg_we               | i_cfg_index, i_cfg_data
//
// The next packet is accepted only once the current one is through; most of that
// time goes to the serial hash modulo. A normal item that finds its slot empty adds
// a search of the rescued pairs, one stored pair after another.
// A scan reads each slot of the configured pool in turn and clears the stale ones.
// After reset a clearing pass writes every pool slot, and no item is accepted meanwhile.
// A result waits in the output register while the next item is taken; a second
// result holds the block until the first is sent.
`default_nettype none
module hashed_aggregator_switch_top
    import has_pkg::*;
#(
    parameter int POOL_DEPTH    = 256,
    parameter int RESCUED_DEPTH = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // opcode, job_id, seq_num, src_worker, value, fan_in, worker_mask,
    // worker_count, ecn_in; zero fill to 136 bits
    input  wire logic [135:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // out_job_id, out_seq, out_worker, out_value, out_fan_in, collided,
    // sw_result, out_mask, out_count, ecn_out, resent_out; 136 bits
    output logic [135:0]       m_axis_tdata,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data
);
    localparam int PW = $clog2(POOL_DEPTH + 1);
    localparam logic [PW-1:0] PMAX = PW'(POOL_DEPTH);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_HASH  = 8'b00000100,
        S_READ  = 8'b00001000,
        S_DEC   = 8'b00010000,
        S_SRCH  = 8'b00100000,
        S_SCANR = 8'b01000000,
        S_SCANW = 8'b10000000
    } t_state;

    t_state    r_state;
    t_in_item  r_in;
    t_in_item  v_in;
    t_out_item r_out;
    logic      r_ovld;
    logic [8:0]  r_pool;
    logic [31:0] r_ecn_th;
    logic [31:0] r_to_th;
    logic [31:0] r_tick;
    logic [31:0] r_egress;
    logic        r_ecn;
    logic [PW-1:0] r_idx;
    logic [PW-1:0] v_pool;
    logic [PW-1:0] v_raddr;
    logic        r_qdone;
    logic        v_qdone;
    logic        v_ofree;

    logic        m_done;
    logic [PW-1:0] m_rem;
    logic        v_mstart;
    logic        q_done, q_hit, v_search, v_push;

    t_slot   rd_slot, v_wslot;
    logic    v_we;
    logic [47:0] v_key;
    logic [31:0] v_bit;
    logic [5:0]  v_cnt;
    logic [31:0] v_hash;

    assign v_in = t_in_item'(s_axis_tdata[131:0]);
    assign v_key = {r_in.job_id, r_in.seq_num};
    assign v_bit = 32'd1 << r_in.src_worker;
    assign v_hash = r_in.job_id * HASH_MUL + {16'd0, r_in.seq_num};

    always_comb begin
        if (r_pool == 9'd0) v_pool = PW'(1);
        else if (32'(r_pool) > 32'(POOL_DEPTH)) v_pool = PMAX;
        else v_pool = PW'(r_pool);
    end

    has_mod #(.W(PW)) u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(v_mstart), .i_num(v_hash),
        .i_div(v_pool), .o_done(m_done), .o_rem(m_rem)
    );

    has_rescue #(.DEPTH(RESCUED_DEPTH)) u_rescue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_search(v_search), .i_push(v_push),
        .i_key(v_key), .o_done(q_done), .o_hit(q_hit)
    );

    has_pool #(.DEPTH(POOL_DEPTH)) u_pool (
        .i_clk(i_clk), .i_raddr(v_raddr), .o_rdata(rd_slot),
        .i_we(v_we), .i_waddr(r_idx), .i_wdata(v_wslot)
    );

    assign v_raddr = m_done ? m_rem : r_idx;
    assign v_qdone = q_done || r_qdone;
    assign v_ofree = !r_ovld || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_out;
    assign v_mstart = (r_state == S_HASH);
    assign v_cnt = (rd_slot.count < 6'd63) ? rd_slot.count + 6'd1 : rd_slot.count;

    // decision on the read slot
    logic      v_emit, v_free;
    t_out_item v_o;
    always_comb begin
        v_we = 1'b0;
        v_wslot = rd_slot;
        v_emit = 1'b0;
        v_free = 1'b0;
        v_push = 1'b0;
        v_search = 1'b0;
        v_o = '{out_job_id: r_in.job_id, out_seq: r_in.seq_num,
                out_worker: {3'd0, r_in.src_worker}, out_value: r_in.value,
                out_fan_in: r_in.fan_in, collided: 1'b0, sw_result: 1'b0,
                out_mask: r_in.worker_mask, out_count: r_in.worker_count,
                ecn_out: r_ecn, resent_out: 1'b0};
        unique case (r_state)
            S_CLEAR: begin
                v_we = 1'b1;
                v_wslot = '0;
            end
            S_DEC: begin
                if (v_ofree) begin
                    if (r_in.opcode == OP_RESEND) begin
                        if (rd_slot.key == v_key) begin
                            if ((rd_slot.mask & v_bit) == 32'd0) begin
                                v_wslot.sum = rd_slot.sum + r_in.value;
                                v_wslot.mask = rd_slot.mask | v_bit;
                                v_wslot.count = v_cnt;
                                v_wslot.ecn = rd_slot.ecn | r_ecn;
                            end
                            v_free = 1'b1;
                            v_push = 1'b1;
                        end else begin
                            v_o.resent_out = 1'b1;
                        end
                        v_emit = 1'b1;
                    end else if (rd_slot.key[47:16] == 32'd0) begin
                        v_search = 1'b1;
                    end else if (rd_slot.key == v_key) begin
                        if ((rd_slot.mask & v_bit) == 32'd0) begin
                            v_wslot.sum = rd_slot.sum + r_in.value;
                            v_wslot.mask = rd_slot.mask | v_bit;
                            v_wslot.count = v_cnt;
                            v_wslot.ecn = rd_slot.ecn | r_ecn;
                            v_wslot.stamp = r_tick;
                            v_we = 1'b1;
                            if (v_cnt >= r_in.fan_in) begin
                                v_free = 1'b1;
                                v_emit = 1'b1;
                            end
                        end
                    end else begin
                        v_o.collided = 1'b1;
                        v_emit = 1'b1;
                    end
                    if (v_free) begin
                        v_o.out_worker = SWITCH_WORKER;
                        v_o.out_value = v_wslot.sum;
                        v_o.sw_result = 1'b1;
                        v_o.out_mask = v_wslot.mask;
                        v_o.out_count = v_wslot.count;
                        v_o.ecn_out = v_wslot.ecn;
                        v_o.resent_out = 1'b0;
                        v_we = 1'b1;
                        v_wslot = '0;
                    end
                end
            end
            S_SRCH: begin
                if (v_qdone && v_ofree) begin
                    if (q_hit) v_emit = 1'b1;
                    else begin
                        v_we = 1'b1;
                        v_wslot = '{key: v_key, sum: r_in.value, mask: r_in.worker_mask,
                                    count: 6'd1, stamp: r_tick, ecn: r_ecn};
                    end
                end
            end
            S_SCANW: begin
                if (rd_slot.key[47:16] != 32'd0 && (r_tick - rd_slot.stamp) > r_to_th) begin
                    v_we = 1'b1;
                    v_wslot = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ovld   <= 1'b0;
            r_pool   <= 9'd256;
            r_ecn_th <= 32'd1;
            r_to_th  <= 32'd3;
            r_tick   <= '0;
            r_egress <= '0;
            r_idx    <= '0;
            r_qdone  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_POOL:    r_pool   <= i_cfg_data[8:0];
                    CFG_ECN:     r_ecn_th <= i_cfg_data;
                    CFG_TIMEOUT: r_to_th  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (v_emit) begin
                r_out  <= v_o;
                r_ovld <= 1'b1;
                if (r_egress != 32'hFFFF_FFFF) r_egress <= r_egress + 32'd1;
            end else if (m_axis_tready) begin
                r_ovld <= 1'b0;
            end
            if (v_search) r_qdone <= 1'b0;
            else if (q_done) r_qdone <= 1'b1;
            unique case (r_state)
                S_CLEAR: begin
                    if (r_idx == PMAX - PW'(1)) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end else r_idx <= r_idx + PW'(1);
                end
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_in <= v_in;
                        unique case (v_in.opcode)
                            OP_NORMAL, OP_RESEND: begin
                                r_tick  <= r_tick + 32'd1;
                                r_ecn   <= v_in.ecn_in | (r_egress > r_ecn_th);
                                r_state <= S_HASH;
                            end
                            OP_SCAN: begin
                                r_idx   <= '0;
                                r_state <= S_SCANR;
                            end
                            default: ;
                        endcase
                    end
                end
                S_HASH: r_state <= S_READ;
                S_READ: begin
                    if (m_done) begin
                        r_idx   <= m_rem;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (v_ofree) begin
                        if (!v_search) r_state <= S_IDLE;
                        else r_state <= S_SRCH;
                    end
                end
                S_SRCH: if (v_qdone && v_ofree) r_state <= S_IDLE;
                S_SCANR: r_state <= S_SCANW;
                S_SCANW: begin
                    if (r_idx == v_pool - PW'(1)) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + PW'(1);
                        r_state <= S_SCANR;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ tb/has_checker.sv @@
// Checker for the hashed aggregator switch: watches the input, output and register channels,
// predicts each result from its own copy of the pool and compares field by field.
// Depends on has_pkg.
`timescale 1ns / 100ps
module has_checker
    import has_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    input  wire logic         i_in_ready,
    input  wire logic [135:0] i_in_data,
    input  wire logic         i_out_valid,
    input  wire logic         i_out_ready,
    input  wire logic [135:0] i_out_data,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data,
    output int                o_fails,
    output int                o_pending,
    output int                o_results
);

    localparam int SLOTS = 256;
    localparam int RESCUE_SLOTS = 256;

    logic [8:0]  pool_slots;
    logic [31:0] ecn_limit;
    logic [31:0] age_limit;
    logic [47:0] key_q   [SLOTS];
    logic [31:0] sum_q   [SLOTS];
    logic [31:0] mask_q  [SLOTS];
    logic [5:0]  count_q [SLOTS];
    logic [31:0] stamp_q [SLOTS];
    logic        ecn_q   [SLOTS];
    logic [47:0] rescued [RESCUE_SLOTS];
    int          rescued_fill;
    logic [31:0] ticks;
    logic [31:0] egress;
    t_out_item   sums_due[$];

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h, want %0h", what, got, want);
        o_fails++;
    endtask

    task automatic clear_slot(int i);
        key_q[i] = '0;
        sum_q[i] = '0;
        mask_q[i] = '0;
        count_q[i] = '0;
        stamp_q[i] = '0;
        ecn_q[i] = 1'b0;
    endtask

    task automatic queue_result(logic [31:0] job, logic [15:0] seq, logic [7:0] wrk,
                                logic [31:0] val, logic [5:0] fan, logic coll, logic fsw,
                                logic [31:0] msk, logic [5:0] cnt, logic ecn, logic rs);
        t_out_item r;
        r.out_job_id = job;
        r.out_seq = seq;
        r.out_worker = wrk;
        r.out_value = val;
        r.out_fan_in = fan;
        r.collided = coll;
        r.sw_result = fsw;
        r.out_mask = msk;
        r.out_count = cnt;
        r.ecn_out = ecn;
        r.resent_out = rs;
        sums_due.push_back(r);
        if (egress != 32'hFFFF_FFFF) egress++;
    endtask

    task automatic aggregate(logic [135:0] d);
        logic [1:0]  op;
        logic [31:0] job;
        logic [15:0] seq;
        logic [4:0]  wid;
        logic [31:0] val;
        logic [5:0]  fan;
        logic [31:0] wmask;
        logic [5:0]  wcnt;
        logic        ecn;
        logic [47:0] key;
        logic [31:0] bitv;
        logic [31:0] hash;
        int          pool;
        int          idx;
        bit          hit;
        op = d[1:0];
        job = d[33:2];
        seq = d[49:34];
        wid = d[54:50];
        val = d[86:55];
        fan = d[92:87];
        wmask = d[124:93];
        wcnt = d[130:125];
        ecn = d[131];
        key = {job, seq};
        bitv = 32'd1 << wid;
        pool = (pool_slots == 0) ? 1 : (pool_slots > SLOTS) ? SLOTS : pool_slots;
        if (op == OP_NONE) return;
        if (op == OP_SCAN) begin
            for (int i = 0; i < pool; i++)
                if (key_q[i][47:16] != 0 && (ticks - stamp_q[i]) > age_limit) clear_slot(i);
            return;
        end
        ticks++;
        if (egress > ecn_limit) ecn = 1'b1;
        hash = job * HASH_MUL + {16'd0, seq};
        idx = hash % pool;
        if (op == OP_RESEND) begin
            if (key_q[idx] == key) begin
                if ((mask_q[idx] & bitv) == 0) begin
                    sum_q[idx] += val;
                    mask_q[idx] |= bitv;
                    if (count_q[idx] < 63) count_q[idx]++;
                    ecn_q[idx] |= ecn;
                end
                queue_result(job, seq, SWITCH_WORKER, sum_q[idx], fan, 1'b0, 1'b1,
                             mask_q[idx], count_q[idx], ecn_q[idx], 1'b0);
                clear_slot(idx);
                if (rescued_fill >= RESCUE_SLOTS) begin
                    for (int i = 0; i < RESCUE_SLOTS - 1; i++) rescued[i] = rescued[i + 1];
                    rescued_fill = RESCUE_SLOTS - 1;
                end
                rescued[rescued_fill] = key;
                rescued_fill++;
            end else begin
                queue_result(job, seq, {3'd0, wid}, val, fan, 1'b0, 1'b0, wmask, wcnt, ecn,
                             1'b1);
            end
            return;
        end
        if (key_q[idx][47:16] == 0) begin
            hit = 0;
            for (int i = 0; i < rescued_fill; i++) if (rescued[i] == key) hit = 1;
            if (hit) begin
                queue_result(job, seq, {3'd0, wid}, val, fan, 1'b0, 1'b0, wmask, wcnt, ecn,
                             1'b0);
            end else begin
                key_q[idx] = key;
                sum_q[idx] = val;
                mask_q[idx] = wmask;
                ecn_q[idx] = ecn;
                count_q[idx] = 6'd1;
                stamp_q[idx] = ticks;
            end
        end else if (key_q[idx] == key) begin
            if ((mask_q[idx] & bitv) != 0) return;
            sum_q[idx] += val;
            mask_q[idx] |= bitv;
            if (count_q[idx] < 63) count_q[idx]++;
            ecn_q[idx] |= ecn;
            stamp_q[idx] = ticks;
            if (count_q[idx] >= fan) begin
                queue_result(job, seq, SWITCH_WORKER, sum_q[idx], fan, 1'b0, 1'b1,
                             mask_q[idx], count_q[idx], ecn_q[idx], 1'b0);
                clear_slot(idx);
            end
        end else begin
            queue_result(job, seq, {3'd0, wid}, val, fan, 1'b1, 1'b0, wmask, wcnt, ecn, 1'b0);
        end
    endtask

    task automatic compare(logic [135:0] d);
        t_out_item   w;
        logic [63:0] got [11];
        logic [63:0] want [11];
        string       names [11];
        names = '{"job", "seq", "worker", "value", "fan_in", "collided", "switch result",
                  "mask", "count", "ecn", "resent"};
        if (sums_due.size() == 0) begin
            report("unexpected item", d[63:0], 64'd0);
            return;
        end
        w = sums_due.pop_front();
        got = '{d[31:0], d[47:32], d[55:48], d[87:56], d[93:88], d[94], d[95],
                d[127:96], d[133:128], d[134], d[135]};
        want = '{w.out_job_id, w.out_seq, w.out_worker, w.out_value, w.out_fan_in,
                 w.collided, w.sw_result, w.out_mask, w.out_count, w.ecn_out,
                 w.resent_out};
        for (int i = 0; i < 11; i++) if (got[i] !== want[i]) report(names[i], got[i], want[i]);
    endtask

    initial begin
        o_fails = 0;
        o_results = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pool_slots <= 9'd256;
            ecn_limit <= 32'd1;
            age_limit <= 32'd3;
            for (int i = 0; i < SLOTS; i++) clear_slot(i);
            rescued_fill = 0;
            ticks = 0;
            egress = 0;
            sums_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                compare(i_out_data);
                o_results++;
            end
            if (i_in_valid && i_in_ready) aggregate(i_in_data);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_POOL:    pool_slots <= i_cfg_data[8:0];
                    CFG_ECN:     ecn_limit <= i_cfg_data;
                    CFG_TIMEOUT: age_limit <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = sums_due.size();
    end

endmodule

@@ tb/tb.sv @@
// Top of the hashed aggregator switch testbench: clock, reset, stimulus, register phases
// and verdict. Depends on has_pkg, has_checker and the block's top level.
`timescale 1ns / 100ps
module tb;
    import has_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE = 1200;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_index = CFG_POOL;
    logic [31:0]  i_cfg_data = '0;
    int           fails;
    int           pending;
    int           results;
    int           cycles = 0;
    int           sent = 0;
    bit           idling = 1;
    bit           long_hold = 0;

    always #6 i_clk = ~i_clk;

    hashed_aggregator_switch_top dut (.*);

    has_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready), .i_out_data(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fails(fails), .o_pending(pending), .o_results(results)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int gap;
        @(negedge i_clk);
        forever begin
            gap = idling ? $urandom_range(0, 16) : 0;
            if (long_hold) begin
                gap = 3000;
                long_hold = 0;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            @(negedge i_clk);
        end
    end

    function automatic logic [135:0] packet(logic [1:0] op, logic [31:0] job, logic [15:0] seq,
                                            logic [4:0] wid, logic [31:0] val, logic [5:0] fan,
                                            logic [31:0] wmask, logic [5:0] wcnt, logic ecn);
        return {4'd0, ecn, wcnt, wmask, fan, val, wid, seq, job, op};
    endfunction

    task automatic offer(logic [135:0] d);
        int gap;
        gap = idling ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata <= d;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        @(negedge i_clk);
        if (d[1:0] != OP_NONE) sent++;
    endtask

    task automatic send(logic [1:0] op, logic [31:0] job, logic [15:0] seq, logic [4:0] wid,
                        logic [5:0] fan);
        offer(packet(op, job, seq, wid, $urandom, fan, 32'd1 << wid, 6'd1, $urandom_range(0, 1)));
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_items(int n, int jobs);
        int r;
        int target;
        target = sent + n;
        while (sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                send(OP_NORMAL, $urandom_range(1, jobs), $urandom_range(0, 7),
                     $urandom_range(0, 31), $urandom_range(0, 5));
            else if (r < 72)
                send(OP_RESEND, $urandom_range(1, jobs), $urandom_range(0, 7),
                     $urandom_range(0, 31), $urandom_range(1, 5));
            else if (r < 76)
                offer(packet(OP_SCAN, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom));
            else if (r < 79)
                offer(packet(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom));
            else if (r < 84)
                send($urandom_range(0, 1), 32'd0, $urandom_range(0, 7), $urandom_range(0, 31),
                     $urandom_range(1, 5));
            else
                offer(packet($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom));
            if (r == 50 && !long_hold) long_hold = 1;
            if (r == 40) settle();
        end
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);

        send(OP_NORMAL, 32'd1, 16'd0, 5'd0, 6'd2);
        send(OP_NORMAL, 32'd1, 16'd0, 5'd1, 6'd2);
        send(OP_NORMAL, 32'd1, 16'd1, 5'd3, 6'd3);
        send(OP_NORMAL, 32'd1, 16'd1, 5'd3, 6'd3);
        send(OP_NORMAL, 32'd1, 16'd1, 5'd4, 6'd3);
        send(OP_RESEND, 32'd1, 16'd1, 5'd5, 6'd3);
        send(OP_NORMAL, 32'd1, 16'd1, 5'd6, 6'd3);
        send(OP_NORMAL, 32'd2, 16'd0, 5'd0, 6'd4);
        send(OP_NORMAL, 32'd1, 16'd31, 5'd2, 6'd4);
        send(OP_RESEND, 32'd9, 16'd9, 5'd9, 6'd2);
        send(OP_NORMAL, 32'd0, 16'd5, 5'd1, 6'd2);
        send(OP_RESEND, 32'd0, 16'd0, 5'd7, 6'd2);
        send(OP_NORMAL, 32'd3, 16'd0, 5'd8, 6'd0);
        send(OP_NORMAL, 32'd3, 16'd0, 5'd9, 6'd0);
        offer(packet(OP_NONE, '1, '1, '1, '1, '1, '1, '1, 1'b1));
        offer(packet(OP_NORMAL, '1, '1, 5'd31, 32'h7FFF_FFFF, 6'd63, '1, 6'd63, 1'b1));
        offer(packet(OP_NORMAL, '1, '1, 5'd0, 32'h8000_0000, 6'd63, '0, 6'd0, 1'b0));
        offer(packet(OP_RESEND, '1, '1, 5'd30, 32'h8000_0000, 6'd32, '1, 6'd32, 1'b0));
        send(OP_NORMAL, 32'd5, 16'd2, 5'd0, 6'd4);
        repeat (4) send(OP_NORMAL, 32'd6, 16'd3, $urandom_range(0, 31), 6'd40);
        offer(packet(OP_SCAN, '0, '0, '0, '0, '0, '0, '0, 1'b0));
        settle();

        random_items(100, 4);
        settle();
        set_reg(CFG_POOL, 32'd1);
        set_reg(CFG_ECN, 32'd0);
        set_reg(CFG_TIMEOUT, 32'd0);
        idling = 0;
        random_items(60, 3);
        idling = 1;
        settle();
        set_reg(CFG_POOL, 32'd300);
        set_reg(CFG_ECN, 32'hFFFF_FFFF);
        set_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        random_items(100, 6);
        settle();
        set_reg(CFG_POOL, 32'd0);
        set_reg(CFG_TIMEOUT, 32'd2);
        random_items(60, 3);
        settle();
        set_reg(CFG_POOL, 32'd7);
        set_reg(CFG_ECN, 32'd40);
        set_reg(CFG_TIMEOUT, 32'd5);
        long_hold = 1;
        random_items(100, 5);
        settle();
        set_reg(CFG_POOL, 32'd256);
        random_items(60, 8);
        settle();

        $display("sent %0d items over six register settings, %0d results checked",
                 sent, results);
        if (fails == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
